@@ rtl/arw_pkg.sv @@
// arw_pkg: shared types and codes for the anti-replay window.
// Holds the command and verdict encodings and the structs passed between stages.
// No dependencies.
package arw_pkg;

    localparam int unsigned CTR_W = 64;

    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_PEEK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        V_NEW     = 3'd0,
        V_FRESH   = 3'd1,
        V_DUP     = 3'd2,
        V_OLD     = 3'd3,
        V_CLEARED = 3'd4
    } verdict_t;

    // One registered item waiting to be checked
    typedef struct packed {
        cmd_t             cmd;
        logic [CTR_W-1:0] counter;
    } item_t;

    // Result of one check
    typedef struct packed {
        logic     accepted;
        verdict_t verdict;
    } result_t;

endpackage

@@ rtl/arw_in_stage.sv @@
// arw_in_stage: input register for the anti-replay window.
// Captures command and counter on each input transfer.
// Depends on arw_pkg.
module arw_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [63:0]         counter,
    input  logic                take,
    output logic                item_valid,
    output arw_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    arw_pkg::item_t item_reg;

    // Accept when empty, or refill when the held item is taken this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd     <= arw_pkg::cmd_t'(command);
            item_reg.counter <= counter;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/arw_window.sv @@
// arw_window: window state, combinational check logic and registered update.
// Holds highest counter, seen-mask and started flag; gives one verdict per item.
// Depends on arw_pkg.
module arw_window
#(
    parameter int unsigned WINDOW_BITS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  arw_pkg::item_t     item,
    output arw_pkg::result_t   result
);

    localparam int unsigned SW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam logic [63:0] WIN = 64'(WINDOW_BITS);

    logic                   started_reg;
    logic                   started_next;
    logic [63:0]            highest_reg;
    logic [63:0]            highest_next;
    logic [WINDOW_BITS-1:0] mask_reg;
    logic [WINDOW_BITS-1:0] mask_next;

    logic [64:0]            diff;
    logic                   above;
    logic [63:0]            jump;
    logic [63:0]            age;
    logic                   far_jump;
    logic                   too_old;
    logic                   seen;
    logic [WINDOW_BITS-1:0] shifted;
    logic [WINDOW_BITS-1:0] age_onehot;
    logic                   record;

    // One subtract serves both directions: borrow clear and non-zero means above
    assign diff     = {1'b0, item.counter} - {1'b0, highest_reg};
    assign jump     = diff[63:0];
    assign above    = !diff[64] && (jump != 64'd0);
    assign age      = 64'd0 - jump;
    assign far_jump = (jump >= WIN);
    assign too_old  = (age >= WIN);
    assign shifted  = mask_reg << jump[SW-1:0];
    assign age_onehot = {{(WINDOW_BITS-1){1'b0}}, 1'b1} << age[SW-1:0];
    assign seen     = |(mask_reg & age_onehot);
    assign record   = (item.cmd == arw_pkg::CMD_CHECK);

    always_comb
    begin
        started_next    = started_reg;
        highest_next    = highest_reg;
        mask_next       = mask_reg;
        result.accepted = 1'b1;
        result.verdict  = arw_pkg::V_NEW;
        unique case (item.cmd)
            arw_pkg::CMD_CLEAR:
            begin
                started_next    = 1'b0;
                highest_next    = 64'd0;
                mask_next       = '0;
                result.accepted = 1'b0;
                result.verdict  = arw_pkg::V_CLEARED;
            end
            arw_pkg::CMD_CHECK,
            arw_pkg::CMD_PEEK,
            arw_pkg::CMD_RSVD:
            begin
                priority if (!started_reg)
                begin
                    if (record)
                    begin
                        started_next = 1'b1;
                        highest_next = item.counter;
                        mask_next    = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
                    end
                end
                else if (above)
                begin
                    if (record)
                    begin
                        mask_next    = (far_jump ? '0 : shifted)
                                     | {{(WINDOW_BITS-1){1'b0}}, 1'b1};
                        highest_next = item.counter;
                    end
                end
                else if (too_old)
                begin
                    result.accepted = 1'b0;
                    result.verdict  = arw_pkg::V_OLD;
                end
                else if (seen)
                begin
                    result.accepted = 1'b0;
                    result.verdict  = arw_pkg::V_DUP;
                end
                else
                begin
                    result.verdict = arw_pkg::V_FRESH;
                    if (record)
                    begin
                        mask_next = mask_reg | age_onehot;
                    end
                end
            end
            default:
            begin
                result.accepted = 1'b0;
                result.verdict  = arw_pkg::V_CLEARED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            highest_reg <= 64'd0;
            mask_reg    <= '0;
        end
        else if (step)
        begin
            started_reg <= started_next;
            highest_reg <= highest_next;
            mask_reg    <= mask_next;
        end
    end

endmodule

@@ rtl/anti_replay_window.sv @@
// anti_replay_window: top level of the sliding-window anti-replay checker.
// Instantiates arw_in_stage and arw_window and holds the result register.
// Depends on arw_pkg.
//
// Usage
//   Input channel (in_valid/in_ready) carries a command and a 64-bit counter.
//   Commands: check (test and record), peek (test only; the unused fourth
//   code behaves as peek) and clear (empty the window).
//   Output channel (out_valid/out_ready) returns one result per input
//   transfer: accepted (new or fresh counter) and a verdict code.
// Pipeline and throughput
//   An item is held in the input register while the window logic judges it;
//   the verdict enters the result register when that register is free or
//   draining, and is then offered on the output channel. One item per cycle
//   is sustained while out_ready stays high; the window state is updated in
//   the same cycle an item moves to the result register, so the next item
//   always sees it.
// Reset
//   rst_n clears the window (not started, highest zero, mask empty) and
//   drops both stage valids.
// Stall
//   While out_ready is low the result is held; the input register still
//   fills once, then in_ready drops until the result is taken.
module anti_replay_window
#(
    parameter int unsigned WINDOW_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [63:0] counter,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [2:0]  verdict
);

    logic             item_valid;
    arw_pkg::item_t   item;
    arw_pkg::result_t result;
    logic             advance;

    logic             out_valid_reg;
    logic             out_valid_next;
    arw_pkg::result_t result_reg;

    // Advance when an item is held and the result register is free or draining
    assign advance = item_valid && (!out_valid_reg || out_ready);

    arw_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .counter    (counter),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    arw_window
    #(
        .WINDOW_BITS (WINDOW_BITS)
    )
    u_window
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item),
        .result (result)
    );

    // Hold the result until the output transfer completes
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = result_reg.accepted;
    assign verdict   = result_reg.verdict;

endmodule

@@ tb/arw_tb_pkg.sv @@
// arw_tb_pkg: window tracker used by the anti_replay_window testbench.
// Predicts each verdict from its own copy of the window state and checks results in order.
// Depends on arw_pkg for the command and verdict encodings.
package arw_tb_pkg;

    import arw_pkg::*;

    localparam int unsigned WINDOW = 64;

    class replay_window_tracker;

        logic [63:0] highest_ctr;
        logic [63:0] seen_bits;
        bit          window_live;
        result_t     pending_verdicts[$];
        int unsigned packets_in;
        int unsigned results_checked;
        int unsigned errors;
        int unsigned verdict_hits[5];

        function new();
            highest_ctr = '0;
            seen_bits   = '0;
            window_live = 1'b0;
        endfunction

        // Judge one counter against the window, update on a check, queue the verdict
        function void note_packet(cmd_t cmd, logic [63:0] ctr);
            bit          record;
            logic [63:0] jump;
            logic [63:0] age;
            result_t     r;
            record = (cmd == CMD_CHECK);
            packets_in++;
            if (cmd == CMD_CLEAR) begin
                highest_ctr = '0;
                seen_bits   = '0;
                window_live = 1'b0;
                r = '{accepted: 1'b0, verdict: V_CLEARED};
            end
            else if (!window_live) begin
                if (record) begin
                    window_live = 1'b1;
                    highest_ctr = ctr;
                    seen_bits   = 64'd1;
                end
                r = '{accepted: 1'b1, verdict: V_NEW};
            end
            else if (ctr > highest_ctr) begin
                if (record) begin
                    jump = ctr - highest_ctr;
                    if (jump >= WINDOW)
                        seen_bits = '0;
                    else
                        seen_bits = (seen_bits << jump) & ({64{1'b1}} >> (64 - WINDOW));
                    seen_bits[0] = 1'b1;
                    highest_ctr  = ctr;
                end
                r = '{accepted: 1'b1, verdict: V_NEW};
            end
            else begin
                age = highest_ctr - ctr;
                if (age >= WINDOW)
                    r = '{accepted: 1'b0, verdict: V_OLD};
                else if (seen_bits[age[5:0]])
                    r = '{accepted: 1'b0, verdict: V_DUP};
                else begin
                    if (record)
                        seen_bits[age[5:0]] = 1'b1;
                    r = '{accepted: 1'b1, verdict: V_FRESH};
                end
            end
            pending_verdicts.push_back(r);
        endfunction

        // Compare one result transfer with the oldest outstanding verdict
        function void check_verdict(logic got_acc, logic [2:0] got_verdict);
            result_t exp_r;
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual accepted=%0b verdict=%0d",
                         $time, got_acc, got_verdict);
                return;
            end
            exp_r = pending_verdicts.pop_front();
            results_checked++;
            verdict_hits[exp_r.verdict]++;
            if (got_acc !== exp_r.accepted) begin
                errors++;
                $display("%0t: accepted mismatch: expected %0b, actual %0b",
                         $time, exp_r.accepted, got_acc);
            end
            if (got_verdict !== exp_r.verdict) begin
                errors++;
                $display("%0t: verdict mismatch: expected %0d (%s), actual %0d",
                         $time, exp_r.verdict, exp_r.verdict.name(), got_verdict);
            end
        endfunction

    endclass

endpackage

@@ tb/anti_replay_window_tb.sv @@
// anti_replay_window_tb: top-level testbench for the sliding-window anti-replay checker.
// Drives directed and random command/counter traffic under varied handshake idling.
// Depends on arw_pkg, arw_tb_pkg and the anti_replay_window RTL.
module anti_replay_window_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import arw_pkg::*;
    import arw_tb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int unsigned STALL_HOLD     = 80;    // long receiver hold-off, in cycles
    localparam int unsigned DRAIN_CYCLES   = 8;     // settle time after the last result
    localparam int unsigned PHASE_ITEMS    = 608;   // random transfers per idling phase

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    cmd_t        command;
    logic [63:0] counter;
    logic        out_valid;
    logic        out_ready;
    logic        accepted;
    logic [2:0]  verdict;

    replay_window_tracker tracker;

    // Idling percentages, changed per phase by the stimulus process
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // Raised once by the stimulus; the receiver process runs the long hold-off and lowers it
    bit          stall_req;
    // Rough running top of the counters sent, used to aim the random traffic at the window
    logic [63:0] lead_ctr;
    int unsigned quiet_cycles;

    always #5 clk = ~clk;

    anti_replay_window #(
        .WINDOW_BITS (WINDOW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .counter   (counter),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .accepted  (accepted),
        .verdict   (verdict)
    );

    // Offer one item; idle beforehand at the sender's rate, then hold the payload
    // steady until the transfer takes place. Valid stays high into the next item
    // when no idle cycle is rolled, so it is never lowered and raised in one step.
    task automatic send_item(input cmd_t cmd, input logic [63:0] ctr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        counter  <= ctr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Walk the window through its corner cases: not started, first counter, duplicates,
    // a jump of exactly the window size and one short of it, the age limit, the reserved
    // command acting as a peek, the counter extremes and clear.
    task automatic directed_traffic();
        logic [63:0] mid;
        mid = 64'h8000_0000_0000_0000;
        send_item(CMD_PEEK,  64'd5);                 // peek before any check
        send_item(CMD_RSVD,  64'd7);                 // reserved code before any check
        send_item(CMD_CHECK, 64'd0);                 // first counter starts the window
        send_item(CMD_CHECK, 64'd0);                 // equal to highest: duplicate
        send_item(CMD_CHECK, 64'd1);
        send_item(CMD_PEEK,  64'd0);
        send_item(CMD_CHECK, 64'd65);                // jump of exactly the window: mask emptied
        send_item(CMD_CHECK, 64'd2);                 // oldest slot in the window, unseen
        send_item(CMD_CHECK, 64'd1);                 // one past the window: too old
        send_item(CMD_CHECK, 64'd2);
        send_item(CMD_PEEK,  64'd30);                // fresh, but no mark
        send_item(CMD_CHECK, 64'd30);
        send_item(CMD_RSVD,  64'd30);
        send_item(CMD_CHECK, 64'd128);               // jump one short of the window: shift
        send_item(CMD_CHECK, 64'd65);                // old highest shifted to the top bit
        send_item(CMD_RSVD,  64'd129);               // new highest seen but not recorded
        send_item(CMD_CHECK, 64'd129);
        send_item(CMD_CHECK, {64{1'b1}});
        send_item(CMD_CHECK, {64{1'b1}});
        send_item(CMD_CHECK, 64'd0);
        send_item(CMD_CLEAR, {64{1'b1}});
        send_item(CMD_PEEK,  64'd0);                 // cleared window behaves as not started
        send_item(CMD_CLEAR, 64'd0);
        send_item(CMD_CHECK, mid);
        send_item(CMD_CHECK, mid - 64'd63);
        send_item(CMD_CHECK, mid - 64'd64);
        lead_ctr = mid;
    endtask

    // Mostly traffic around the current highest counter (advances, probes inside and just
    // beyond the window, jumps near the window size), with some counters anywhere and clears
    task automatic random_traffic(input int unsigned n_items);
        cmd_t        cmd;
        logic [63:0] ctr;
        int unsigned pick;
        for (int unsigned i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            cmd  = ($urandom_range(3) == 0) ? CMD_PEEK : CMD_CHECK;
            if ($urandom_range(29) == 0)
                cmd = CMD_RSVD;
            if (pick < 35)
                ctr = lead_ctr + 64'($urandom_range(1, 6));
            else if (pick < 75)
                ctr = lead_ctr - 64'($urandom_range(0, 70));
            else if (pick < 87)
                ctr = lead_ctr + 64'($urandom_range(60, 68));
            else if (pick < 96)
                ctr = {$urandom, $urandom};
            else begin
                cmd = CMD_CLEAR;
                ctr = {$urandom, $urandom};
            end
            // Pull the lead back once it nears the top so advances do not wrap for long
            if (lead_ctr[63:60] == 4'hF) begin
                cmd      = CMD_CLEAR;
                lead_ctr = {1'b0, 31'($urandom), $urandom_range(2**30, 0)};
            end
            if (cmd == CMD_CHECK && ctr > lead_ctr)
                lead_ctr = ctr;
            send_item(cmd, ctr);
        end
    endtask

    // Receiver: roll out_ready each cycle, or hold it low for a long stretch on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req) begin
                out_ready <= 1'b0;
                repeat (STALL_HOLD) @(posedge clk);
                stall_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Observe both channels at the edge; a result never shares an edge with its own input
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                tracker.check_verdict(accepted, verdict);
            if (in_valid && in_ready)
                tracker.note_packet(command, counter);
        end
    end

    // Watchdog: give up when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d verdicts outstanding",
                         $time, quiet_cycles, tracker.pending_verdicts.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_CHECK;
        counter       = '0;
        stall_req     = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 23;
        recv_idle_pct = 57;
        lead_ctr      = '0;
        tracker       = new();

        // Hold reset low, then release it at an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Sender lightly idle, receiver slow
        directed_traffic();
        random_traffic(PHASE_ITEMS);

        // Swap the idling rates
        send_idle_pct = 57;
        recv_idle_pct = 23;
        random_traffic(PHASE_ITEMS);

        // No idling at all; open with a long receiver hold-off so the pipe fills and
        // in_ready drops while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req     = 1'b1;
        random_traffic(PHASE_ITEMS);
        in_valid <= 1'b0;

        // Drain outstanding verdicts, then wait out the settle time for any stray result
        while (tracker.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items and checked %0d results across three idling phases.",
                 tracker.packets_in, tracker.results_checked);
        $display("Verdicts seen: new %0d, fresh %0d, duplicate %0d, too old %0d, cleared %0d.",
                 tracker.verdict_hits[V_NEW], tracker.verdict_hits[V_FRESH],
                 tracker.verdict_hits[V_DUP], tracker.verdict_hits[V_OLD],
                 tracker.verdict_hits[V_CLEARED]);
        if (tracker.errors == 0 && tracker.pending_verdicts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/arw_pkg.sv
rtl/arw_in_stage.sv
rtl/arw_window.sv
rtl/anti_replay_window.sv
tb/arw_tb_pkg.sv
tb/anti_replay_window_tb.sv
